// ===== rtl/vgn_pkg.sv =====
`timescale 1ns / 1ps

package vgn_pkg;

    localparam int DEF_MAX_X       = 128;
    localparam int DEF_MAX_Y       = 128;
    localparam int DEF_MAX_Z       = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // gradient word and unit length in Q1.14
    localparam int GRAD_W = 16;
    localparam int UNIT   = 16384;

    // register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [7:0]  RST_SIZE_X = 8'd128;
    localparam logic [7:0]  RST_SIZE_Y = 8'd128;
    localparam logic [10:0] RST_SIZE_Z = 11'd128;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RDW,
        S_WR,
        S_DIFF,
        S_SQ,
        S_SQRT,
        S_DINIT,
        S_DSTEP,
        S_DEND,
        S_EMIT
    } t_state;

    function automatic int clamp_size(input int v, input int hi);
        int r;
        r = v;
        if (v < 2) r = 2;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// ===== rtl/vgn_plane_mem.sv =====
`timescale 1ns / 1ps

module vgn_plane_mem #(
    parameter int DEPTH = 2 * 128 * 128,
    parameter int AW    = 15,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/volume_gradient_normalizer.sv =====
`timescale 1ns / 1ps

// Normalised central-difference gradient of a volume streamed x fastest, then y, then z.
// Voxel (x,y,z-1) leaves when sample (x,y,z) is taken; the final plane leaves one voxel
// per drain beat. Two planes live in a single-port RAM, so an emitting beat reads its
// six neighbours one at a time, each with a read and a wait state, writes the sample
// on a sample beat, then runs a shared datapath: squaring of the three components, a
// bit-serial square root over (2*SAMPLE_BITS+4)/2 bits (18 at 16-bit samples) and three
// restoring divisions. A non-emitting sample beat only writes; stray beats are ignored.
// Any write to a size register restarts the volume. No clearing pass is needed.
module volume_gradient_normalizer
    import vgn_pkg::*;
#(
    parameter int MAX_X       = vgn_pkg::DEF_MAX_X,
    parameter int MAX_Y       = vgn_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = vgn_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgn_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [15:0]              o_grad_x,
    output logic signed [15:0]              o_grad_y,
    output logic signed [15:0]              o_grad_z,
    output logic [6:0]                      o_vox_x,
    output logic [6:0]                      o_vox_y,
    output logic [9:0]                      o_vox_z,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vgn_pkg::APB_AW-1:0]      paddr,
    input  logic [vgn_pkg::APB_DW-1:0]      pwdata,
    output logic [vgn_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    localparam int XW    = $clog2(MAX_X);
    localparam int YW    = $clog2(MAX_Y);
    localparam int ZW    = $clog2(MAX_Z);
    localparam int NXW   = $clog2(MAX_X + 1);
    localparam int NYW   = $clog2(MAX_Y + 1);
    localparam int NZW   = $clog2(MAX_Z + 1);
    localparam int PLANE = MAX_X * MAX_Y;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SB    = SAMPLE_BITS;
    localparam int DW    = SB + 2;
    localparam int MW    = SB + 1;
    localparam int PW    = 2 * MW;
    localparam int SUMW  = (2 * SB + 4 > 64) ? 64 : 2 * SB + 4;
    localparam int LW    = SUMW / 2;
    localparam int IW    = $clog2(LW);
    localparam int NW    = ((SB + 16 > LW) ? SB + 16 : LW) + 1;
    localparam int HW    = NW - 16;
    localparam int RW    = LW + 1;
    localparam int CMPW  = (HW > RW) ? HW : RW;

    // neighbour read order
    localparam logic [2:0] RD_XA    = 3'd0;
    localparam logic [2:0] RD_XB    = 3'd1;
    localparam logic [2:0] RD_YA    = 3'd2;
    localparam logic [2:0] RD_YB    = 3'd3;
    localparam logic [2:0] RD_SELF  = 3'd4;
    localparam logic [2:0] RD_BELOW = 3'd5;

    function automatic logic [AW-1:0] f_addr(input logic slot, input logic [XW-1:0] x,
                                             input logic [YW-1:0] y);
        logic [AW-1:0] a;
        a = (slot ? AW'(PLANE) : AW'(0)) + AW'(y * MAX_X) + AW'(x);
        return a;
    endfunction

    function automatic logic signed [DW-1:0] f_diff(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b,
                                                    input logic dbl);
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(b);
        if (dbl) d = d <<< 1;
        return d;
    endfunction

    function automatic logic [MW-1:0] f_mag(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] t;
        t = d[DW-1] ? -d : d;
        return t[MW-1:0];
    endfunction

    // configuration
    logic [7:0]  r_size_x;
    logic [7:0]  r_size_y;
    logic [10:0] r_size_z;
    logic        w_cfg_wr;

    // control
    t_state       r_state, n_state;
    logic [XW-1:0] r_pos_x, n_pos_x;
    logic [YW-1:0] r_pos_y, n_pos_y;
    logic [ZW-1:0] r_pos_z, n_pos_z;
    logic          r_draining, n_draining;
    logic          r_oval, n_oval;

    // working set
    logic [XW-1:0] r_ex, n_ex;
    logic [YW-1:0] r_ey, n_ey;
    logic [ZW-1:0] r_ez, n_ez;
    logic          r_slot, n_slot;
    logic          r_wslot, n_wslot;
    logic          r_do_emit, n_do_emit;
    logic          r_do_wr, n_do_wr;
    logic          r_xlo, n_xlo, r_xhi, n_xhi;
    logic          r_ylo, n_ylo, r_yhi, n_yhi;
    logic          r_zlo, n_zlo, r_zhi, n_zhi;
    logic          r_last, n_last;
    logic signed [SB-1:0] r_smp, n_smp;
    logic signed [SB-1:0] r_above, n_above;
    logic signed [SB-1:0] r_nb [6];
    logic signed [SB-1:0] n_nb [6];
    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] n_d [3];
    logic [2:0]    r_rk, n_rk;
    logic [1:0]    r_k, n_k;
    logic [IW-1:0] r_i, n_i;
    logic [3:0]    r_j, n_j;
    logic [SUMW-1:0] r_sum, n_sum;
    logic [SUMW-1:0] r_rt, n_rt;
    logic [RW-1:0] r_rem, n_rem;
    logic [15:0]   r_nlo, n_nlo;
    logic [15:0]   r_q, n_q;
    logic signed [GRAD_W-1:0] r_g [3];
    logic signed [GRAD_W-1:0] n_g [3];
    logic signed [GRAD_W-1:0] r_o_g [3];
    logic signed [GRAD_W-1:0] n_o_g [3];
    logic [XW-1:0] r_o_x, n_o_x;
    logic [YW-1:0] r_o_y, n_o_y;
    logic [ZW-1:0] r_o_z, n_o_z;
    logic          r_o_last, n_o_last;

    // combinational helpers
    logic [NXW-1:0] w_nx;
    logic [NYW-1:0] w_ny;
    logic [NZW-1:0] w_nz;
    logic [NZW-1:0] w_nzm1;
    logic           w_in_acc, w_smp_go, w_drn_go;
    logic           w_x_wrap, w_y_wrap, w_z_wrap;
    logic [AW-1:0]  w_addr, w_rd_addr;
    logic           w_we;
    logic signed [SB-1:0] w_rdata;
    logic [MW-1:0]  w_mag;
    logic [PW-1:0]  w_sq;
    logic [SUMW-1:0] w_bit, w_rb, w_rt_next;
    logic           w_take;
    logic [LW-1:0]  w_len;
    logic [RW-1:0]  w_dv;
    logic [NW-1:0]  w_num;
    logic [HW-1:0]  w_hi;
    logic           w_ovf;
    logic [RW:0]    w_t;
    logic           w_ge;
    logic [15:0]    w_qs;

    assign w_nx   = NXW'(clamp_size(int'(r_size_x), MAX_X));
    assign w_ny   = NYW'(clamp_size(int'(r_size_y), MAX_Y));
    assign w_nz   = NZW'(clamp_size(int'(r_size_z), MAX_Z));
    assign w_nzm1 = w_nz - NZW'(1);

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_smp_go = w_in_acc && (i_kind == KIND_SAMPLE) && !r_draining;
    assign w_drn_go = w_in_acc && (i_kind == KIND_DRAIN) && r_draining;
    assign w_x_wrap = (NXW'(r_pos_x) + NXW'(1)) == w_nx;
    assign w_y_wrap = (NYW'(r_pos_y) + NYW'(1)) == w_ny;
    assign w_z_wrap = (NZW'(r_pos_z) + NZW'(1)) == w_nz;

    // neighbour addresses
    always_comb begin
        case (r_rk)
            RD_XA:    w_rd_addr = f_addr(r_slot, r_xhi ? r_ex : r_ex + XW'(1), r_ey);
            RD_XB:    w_rd_addr = f_addr(r_slot, r_xlo ? r_ex : r_ex - XW'(1), r_ey);
            RD_YA:    w_rd_addr = f_addr(r_slot, r_ex, r_yhi ? r_ey : r_ey + YW'(1));
            RD_YB:    w_rd_addr = f_addr(r_slot, r_ex, r_ylo ? r_ey : r_ey - YW'(1));
            RD_SELF:  w_rd_addr = f_addr(r_slot, r_ex, r_ey);
            default:  w_rd_addr = f_addr(~r_slot, r_ex, r_ey);
        endcase
    end

    assign w_we   = (r_state == S_WR);
    assign w_addr = w_we ? f_addr(r_wslot, r_ex, r_ey) : w_rd_addr;

    vgn_plane_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SB)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_smp),
        .o_rdata (w_rdata)
    );

    // shared arithmetic
    assign w_mag     = f_mag(r_d[r_k]);
    assign w_sq      = w_mag * w_mag;
    assign w_bit     = SUMW'(1) << (2 * r_i);
    assign w_rb      = r_rt + w_bit;
    assign w_take    = (r_sum >= w_rb);
    assign w_rt_next = w_take ? (r_rt >> 1) + w_bit : (r_rt >> 1);
    assign w_len     = r_rt[LW-1:0];
    assign w_dv      = {w_len, 1'b0};
    assign w_num     = (NW'(w_mag) << 15) + NW'(w_len);
    assign w_hi      = w_num[NW-1:16];
    assign w_ovf     = CMPW'(w_hi) >= CMPW'(w_dv);
    assign w_t       = {r_rem, r_nlo[15]};
    assign w_ge      = w_t >= {1'b0, w_dv};
    assign w_qs      = (r_q > 16'(UNIT)) ? 16'(UNIT) : r_q;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_smp_go) n_state = (r_pos_z != '0) ? S_RD : S_WR;
                else if (w_drn_go) n_state = S_RD;
            end
            S_RD:    n_state = S_RDW;
            S_RDW: begin
                if (r_rk == RD_BELOW) n_state = r_do_wr ? S_WR : S_DIFF;
                else n_state = S_RD;
            end
            S_WR:    n_state = r_do_emit ? S_DIFF : S_IDLE;
            S_DIFF:  n_state = S_SQ;
            S_SQ:    n_state = (r_k == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT: begin
                if (r_i == '0) n_state = (w_rt_next == '0) ? S_EMIT : S_DINIT;
            end
            S_DINIT: n_state = w_ovf ? S_DEND : S_DSTEP;
            S_DSTEP: n_state = (r_j == 4'd15) ? S_DEND : S_DSTEP;
            S_DEND:  n_state = (r_k == 2'd2) ? S_EMIT : S_DINIT;
            S_EMIT: begin
                if (!r_oval || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pos_x = r_pos_x;  n_pos_y = r_pos_y;  n_pos_z = r_pos_z;
        n_draining = r_draining;
        n_oval = r_oval;
        n_ex = r_ex;  n_ey = r_ey;  n_ez = r_ez;
        n_slot = r_slot;  n_wslot = r_wslot;
        n_do_emit = r_do_emit;  n_do_wr = r_do_wr;
        n_xlo = r_xlo;  n_xhi = r_xhi;  n_ylo = r_ylo;  n_yhi = r_yhi;
        n_zlo = r_zlo;  n_zhi = r_zhi;  n_last = r_last;
        n_smp = r_smp;  n_above = r_above;
        n_nb = r_nb;  n_d = r_d;  n_g = r_g;
        n_rk = r_rk;  n_k = r_k;  n_i = r_i;  n_j = r_j;
        n_sum = r_sum;  n_rt = r_rt;  n_rem = r_rem;  n_nlo = r_nlo;  n_q = r_q;
        n_o_g = r_o_g;  n_o_x = r_o_x;  n_o_y = r_o_y;  n_o_z = r_o_z;
        n_o_last = r_o_last;

        if (r_oval && i_ready) n_oval = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_rk = RD_XA;
                n_ex = r_pos_x;
                n_ey = r_pos_y;
                n_xlo = (r_pos_x == '0);
                n_xhi = w_x_wrap;
                n_ylo = (r_pos_y == '0);
                n_yhi = w_y_wrap;
                if (w_smp_go) begin
                    n_smp = i_sample;
                    n_above = i_sample;
                    n_wslot = r_pos_z[0];
                    n_slot = ~r_pos_z[0];
                    n_ez = r_pos_z - ZW'(1);
                    n_do_wr = 1'b1;
                    n_do_emit = (r_pos_z != '0);
                    n_zlo = (r_pos_z == ZW'(1));
                    n_zhi = (NZW'(r_pos_z) == w_nz);
                    n_last = w_x_wrap && w_y_wrap && (NZW'(r_pos_z) == w_nz);
                    n_pos_x = w_x_wrap ? '0 : r_pos_x + XW'(1);
                    if (w_x_wrap) begin
                        n_pos_y = w_y_wrap ? '0 : r_pos_y + YW'(1);
                        if (w_y_wrap) begin
                            n_pos_z = w_z_wrap ? '0 : r_pos_z + ZW'(1);
                            if (w_z_wrap) n_draining = 1'b1;
                        end
                    end
                end else if (w_drn_go) begin
                    n_above = '0;
                    n_slot = w_nzm1[0];
                    n_ez = ZW'(w_nzm1);
                    n_do_wr = 1'b0;
                    n_do_emit = 1'b1;
                    n_zlo = 1'b0;
                    n_zhi = 1'b1;
                    n_last = w_x_wrap && w_y_wrap;
                    n_pos_x = w_x_wrap ? '0 : r_pos_x + XW'(1);
                    if (w_x_wrap) begin
                        n_pos_y = w_y_wrap ? '0 : r_pos_y + YW'(1);
                        if (w_y_wrap) n_draining = 1'b0;
                    end
                end
            end
            S_RDW: begin
                n_nb[r_rk] = w_rdata;
                n_rk = r_rk + 3'd1;
            end
            S_DIFF: begin
                n_d[0] = f_diff(r_nb[RD_XA], r_nb[RD_XB], r_xlo || r_xhi);
                n_d[1] = f_diff(r_nb[RD_YA], r_nb[RD_YB], r_ylo || r_yhi);
                if (r_zlo) n_d[2] = f_diff(r_above, r_nb[RD_SELF], 1'b1);
                else if (r_zhi) n_d[2] = f_diff(r_nb[RD_SELF], r_nb[RD_BELOW], 1'b1);
                else n_d[2] = f_diff(r_above, r_nb[RD_BELOW], 1'b0);
                n_k = 2'd0;
                n_sum = '0;
                n_rt = '0;
            end
            S_SQ: begin
                n_sum = r_sum + SUMW'(w_sq);
                n_k = r_k + 2'd1;
                n_i = IW'(LW - 1);
            end
            S_SQRT: begin
                n_rt = w_rt_next;
                if (w_take) n_sum = r_sum - w_rb;
                n_i = r_i - IW'(1);
                n_k = 2'd0;
                if (r_i == '0 && w_rt_next == '0) begin
                    n_g[0] = '0;
                    n_g[1] = '0;
                    n_g[2] = '0;
                end
            end
            S_DINIT: begin
                n_rem = RW'(w_hi);
                n_nlo = w_num[15:0];
                n_q = w_ovf ? 16'(UNIT) : 16'd0;
                n_j = 4'd0;
            end
            S_DSTEP: begin
                n_rem = w_ge ? RW'(w_t - {1'b0, w_dv}) : RW'(w_t);
                n_q = {r_q[14:0], w_ge};
                n_nlo = {r_nlo[14:0], 1'b0};
                n_j = r_j + 4'd1;
            end
            S_DEND: begin
                n_g[r_k] = r_d[r_k][DW-1] ? -w_qs : w_qs;
                n_k = r_k + 2'd1;
            end
            S_EMIT: begin
                if (!r_oval || i_ready) begin
                    n_oval = 1'b1;
                    n_o_g = r_g;
                    n_o_x = r_ex;
                    n_o_y = r_ey;
                    n_o_z = r_ez;
                    n_o_last = r_last;
                end
            end
            default: ;
        endcase

        if (w_cfg_wr) begin
            n_pos_x = '0;
            n_pos_y = '0;
            n_pos_z = '0;
            n_draining = 1'b0;
        end
    end

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[3:2] inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z});

    always_comb begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = APB_DW'(r_size_x);
            REG_SIZE_Y: prdata = APB_DW'(r_size_y);
            REG_SIZE_Z: prdata = APB_DW'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= RST_SIZE_X;
            r_size_y <= RST_SIZE_Y;
            r_size_z <= RST_SIZE_Z;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SIZE_X: r_size_x <= pwdata[7:0];
                REG_SIZE_Y: r_size_y <= pwdata[7:0];
                REG_SIZE_Z: r_size_z <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_pos_z    <= '0;
            r_draining <= 1'b0;
            r_oval     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_pos_z    <= n_pos_z;
            r_draining <= n_draining;
            r_oval     <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex <= n_ex;  r_ey <= n_ey;  r_ez <= n_ez;
        r_slot <= n_slot;  r_wslot <= n_wslot;
        r_do_emit <= n_do_emit;  r_do_wr <= n_do_wr;
        r_xlo <= n_xlo;  r_xhi <= n_xhi;  r_ylo <= n_ylo;  r_yhi <= n_yhi;
        r_zlo <= n_zlo;  r_zhi <= n_zhi;  r_last <= n_last;
        r_smp <= n_smp;  r_above <= n_above;
        r_nb <= n_nb;  r_d <= n_d;  r_g <= n_g;
        r_rk <= n_rk;  r_k <= n_k;  r_i <= n_i;  r_j <= n_j;
        r_sum <= n_sum;  r_rt <= n_rt;  r_rem <= n_rem;  r_nlo <= n_nlo;  r_q <= n_q;
        r_o_g <= n_o_g;  r_o_x <= n_o_x;  r_o_y <= n_o_y;  r_o_z <= n_o_z;
        r_o_last <= n_o_last;
    end

    assign o_valid  = r_oval;
    assign o_grad_x = r_o_g[0];
    assign o_grad_y = r_o_g[1];
    assign o_grad_z = r_o_g[2];
    assign o_vox_x  = 7'(r_o_x);
    assign o_vox_y  = 7'(r_o_y);
    assign o_vox_z  = 10'(r_o_z);
    assign o_last   = r_o_last;

`ifndef ASSERT_OFF
    // restoring division keeps its partial remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DSTEP |-> r_rem < w_dv)
        else $error("division remainder out of range");

    // drain walks the last plane with the plane counter parked at zero
    a_drain_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> r_pos_z == '0)
        else $error("plane counter moved while draining");

    // the final voxel is only shown once the drain has finished
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !r_draining)
        else $error("final voxel out while still draining");

    // only three components to square and to divide
    a_sq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ || r_state == S_DEND |-> r_k <= 2'd2)
        else $error("component counter overran");
`endif

endmodule
